### hdl/hrhp_pkg.sv
// Package for the HTTP response header parser.
// Holds the byte codes, the prefix tables and the decimal converter state type.
// No dependencies.
package hrhp_pkg;

  localparam int LINE_BUFFER_BYTES_DEF = 64;

  localparam int LEN_PREFIX_SIZE = 16;
  localparam int TAG_PREFIX_SIZE = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_BEGIN = 1'b1;

  // Decimal converter phases
  localparam logic [1:0] NUM_SKIP   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_DONE   = 2'd2;

  localparam logic [31:0] NUM_CAP     = 32'h8000_0000;
  localparam logic [31:0] NUM_POS_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] value;
    logic        negative;
    logic [1:0]  phase;
  } num_t;

  localparam num_t NUM_CLEAR = '{value: 32'd0, negative: 1'b0, phase: NUM_SKIP};

  function automatic logic [7:0] lower_case(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  // "content-length: " in lower case
  function automatic logic [7:0] len_prefix_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h6C; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3A; // :
      4'd15:   c = 8'h20; // space
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "etag: " in lower case
  function automatic logic [7:0] tag_prefix_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h65; // e
      3'd1:    c = 8'h74; // t
      3'd2:    c = 8'h61; // a
      3'd3:    c = 8'h67; // g
      3'd4:    c = 8'h3A; // :
      3'd5:    c = 8'h20; // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hdl/hrhp_if.sv
// Channel interfaces for the HTTP response header parser.
// Request carries opcode and data byte, response carries the parse results.
// Depends on nothing.
interface hrhp_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source(output valid, output opcode, output data_byte, input ready);
  modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

interface hrhp_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] status_code;
  logic               header_done;
  logic signed [31:0] content_length;
  logic [7:0]         etag_byte;
  logic               etag_byte_valid;
  logic               etag_commit;
  logic [5:0]         etag_length;

  modport source(output valid, output status_code, output header_done,
                 output content_length, output etag_byte, output etag_byte_valid,
                 output etag_commit, output etag_length, input ready);
  modport sink(input valid, input status_code, input header_done,
               input content_length, input etag_byte, input etag_byte_valid,
               input etag_commit, input etag_length, output ready);
endinterface

### hdl/http_response_header_parser.sv
// HTTP response header parser, top level.
// Parse state, result register and handshake. Depends on hrhp_pkg, hrhp_if, hrhp_num.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------------
//   req     | in  | opcode, data_byte
//   rsp     | out | status_code, header_done, content_length, etag_byte,
//           |     | etag_byte_valid, etag_commit, etag_length
//
// One byte per cycle while rsp is ready: each transaction updates the parse registers through short
// combinational logic (prefix compare, multiply-by-ten shift add) and loads the result
// register in the same edge, so the result shows in the cycle after its byte and a new byte can be
// taken every cycle. rst clears the parse state and the result valid. When rsp stalls,
// req stays ready only until the result register holds an untaken result.
module http_response_header_parser
  import hrhp_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEF
)(
  input  logic       clk,
  input  logic       rst,
  hrhp_req_if.sink   req,
  hrhp_rsp_if.source rsp
);

  localparam int PosW = $clog2(LINE_BUFFER_BYTES);
  localparam logic [PosW-1:0] PosLimit = PosW'(LINE_BUFFER_BYTES - 1);
  localparam logic [PosW-1:0] PosLen   = PosW'(LEN_PREFIX_SIZE);
  localparam logic [PosW-1:0] PosTag   = PosW'(TAG_PREFIX_SIZE);
  localparam logic [PosW-1:0] PosOne   = PosW'(1);

  // parse state
  logic [1:0]      spaces_counted, spaces_counted_next;
  logic [31:0]     stored_status, stored_status_next;
  logic [PosW-1:0] line_position, line_position_next;
  logic [7:0]      previous_byte, previous_byte_next;
  logic [1:0]      newline_run, newline_run_next;
  logic            in_header, in_header_next;
  logic [31:0]     stored_length, stored_length_next;
  logic            length_prefix_ok, length_prefix_ok_next;
  logic            tag_prefix_ok, tag_prefix_ok_next;
  num_t            num, num_next;
  logic [5:0]      tag_count, tag_count_next;

  // result register
  logic            out_valid;
  logic [7:0]      ebyte;
  logic            evalid, ecommit;
  logic [5:0]      elen;
  logic [7:0]      etag_byte_r;
  logic            etag_byte_valid_r, etag_commit_r, header_done_r;
  logic [5:0]      etag_length_r;
  logic [31:0]     status_r, length_r;

  num_t            num_fed;
  logic [31:0]     num_value;
  logic            accept;
  logic [7:0]      b;
  logic [7:0]      b_low;
  logic [1:0]      run_inc;

  hrhp_num u_num (
    .cur       (num),
    .data_byte (req.data_byte),
    .fed       (num_fed),
    .result    (num_value)
  );

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign b         = req.data_byte;
  assign b_low     = lower_case(b);
  assign run_inc   = (newline_run == 2'd3) ? 2'd3 : newline_run + 2'd1;

  always_comb begin
    spaces_counted_next   = spaces_counted;
    stored_status_next    = stored_status;
    line_position_next    = line_position;
    previous_byte_next    = previous_byte;
    newline_run_next      = newline_run;
    in_header_next        = in_header;
    stored_length_next    = stored_length;
    length_prefix_ok_next = length_prefix_ok;
    tag_prefix_ok_next    = tag_prefix_ok;
    num_next              = num;
    tag_count_next        = tag_count;
    ebyte   = 8'd0;
    evalid  = 1'b0;
    ecommit = 1'b0;
    elen    = 6'd0;

    if (req.opcode == OP_BEGIN) begin
      // restart everything but the content length
      spaces_counted_next   = 2'd0;
      stored_status_next    = 32'd0;
      previous_byte_next    = 8'd0;
      newline_run_next      = 2'd0;
      in_header_next        = 1'b1;
      line_position_next    = '0;
      length_prefix_ok_next = 1'b1;
      tag_prefix_ok_next    = 1'b1;
      tag_count_next        = 6'd0;
      num_next              = NUM_CLEAR;
    end else if (stored_status == 32'd0) begin
      // status line; a zero status leaves the block deaf until restart
      if (spaces_counted < 2'd2) begin
        if (b == CH_SPACE) begin
          spaces_counted_next = spaces_counted + 2'd1;
          if (spaces_counted == 2'd1) begin
            stored_status_next = num_value;
          end
          line_position_next    = '0;
          length_prefix_ok_next = 1'b1;
          tag_prefix_ok_next    = 1'b1;
          tag_count_next        = 6'd0;
          num_next              = NUM_CLEAR;
        end else if (line_position < PosLimit) begin
          num_next           = num_fed;
          line_position_next = line_position + PosOne;
        end
      end
    end else begin
      if (b == CH_LF || b == CH_CR) begin
        if (b == CH_LF && (previous_byte == CH_CR || previous_byte == CH_LF)) begin
          newline_run_next = run_inc;
          if (run_inc == 2'd2) begin
            in_header_next = 1'b0;
          end
        end
        if (length_prefix_ok && line_position >= PosLen) begin
          stored_length_next = num_value;
        end
        if (tag_prefix_ok && line_position >= PosTag) begin
          ecommit = 1'b1;
          elen    = tag_count;
        end
        line_position_next    = '0;
        length_prefix_ok_next = 1'b1;
        tag_prefix_ok_next    = 1'b1;
        tag_count_next        = 6'd0;
        num_next              = NUM_CLEAR;
      end else begin
        newline_run_next = 2'd0;
        if (line_position < PosLimit) begin
          if (line_position < PosLen) begin
            if (b_low != len_prefix_char(line_position[3:0])) begin
              length_prefix_ok_next = 1'b0;
            end
          end else begin
            num_next = num_fed;
          end
          if (line_position < PosTag) begin
            if (b_low != tag_prefix_char(line_position[2:0])) begin
              tag_prefix_ok_next = 1'b0;
            end
          end else if (tag_prefix_ok) begin
            ebyte          = b;
            evalid         = 1'b1;
            tag_count_next = tag_count + 6'd1;
          end
          line_position_next = line_position + PosOne;
        end
      end
      previous_byte_next = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spaces_counted   <= 2'd0;
      stored_status    <= 32'd0;
      line_position    <= '0;
      previous_byte    <= 8'd0;
      newline_run      <= 2'd0;
      in_header        <= 1'b1;
      stored_length    <= 32'd0;
      length_prefix_ok <= 1'b1;
      tag_prefix_ok    <= 1'b1;
      num              <= NUM_CLEAR;
      tag_count        <= 6'd0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        spaces_counted   <= spaces_counted_next;
        stored_status    <= stored_status_next;
        line_position    <= line_position_next;
        previous_byte    <= previous_byte_next;
        newline_run      <= newline_run_next;
        in_header        <= in_header_next;
        stored_length    <= stored_length_next;
        length_prefix_ok <= length_prefix_ok_next;
        tag_prefix_ok    <= tag_prefix_ok_next;
        num              <= num_next;
        tag_count        <= tag_count_next;
        out_valid        <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload; hold while the transaction waits downstream
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r          <= stored_status_next;
      header_done_r     <= !in_header_next;
      length_r          <= stored_length_next;
      etag_byte_r       <= ebyte;
      etag_byte_valid_r <= evalid;
      etag_commit_r     <= ecommit;
      etag_length_r     <= elen;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status_code     = status_r;
  assign rsp.header_done     = header_done_r;
  assign rsp.content_length  = length_r;
  assign rsp.etag_byte       = etag_byte_r;
  assign rsp.etag_byte_valid = etag_byte_valid_r;
  assign rsp.etag_commit     = etag_commit_r;
  assign rsp.etag_length     = etag_length_r;

endmodule

### hdl/hrhp_num.sv
// Streaming decimal converter step for the header parser.
// Feeds one byte into the converter state and gives the saturated value.
// Depends on hrhp_pkg.
module hrhp_num
  import hrhp_pkg::*;
(
  input  num_t        cur,
  input  logic [7:0]  data_byte,
  output num_t        fed,
  output logic [31:0] result
);

  logic        is_digit;
  logic        is_space;
  logic [31:0] digit_val;
  logic [35:0] times_ten;
  logic [35:0] capped;

  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_space  = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
  assign digit_val = {28'd0, data_byte[3:0]};

  // value * 10 + digit as two shifted adds
  assign times_ten = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0}
                   + {4'd0, digit_val};
  assign capped    = (times_ten > {4'd0, NUM_CAP}) ? {4'd0, NUM_CAP} : times_ten;

  always_comb begin
    fed = cur;
    case (cur.phase)
      NUM_SKIP: begin
        if (is_space) begin
          fed = cur;
        end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
          fed.negative = (data_byte == CH_MINUS);
          fed.phase    = NUM_DIGITS;
        end else if (is_digit) begin
          fed.value = digit_val;
          fed.phase = NUM_DIGITS;
        end else begin
          fed.phase = NUM_DONE;
        end
      end
      NUM_DIGITS: begin
        if (is_digit) begin
          fed.value = capped[31:0];
        end else begin
          fed.phase = NUM_DONE;
        end
      end
      default: fed = cur;
    endcase
  end

  assign result = cur.negative ? (32'd0 - cur.value)
                : ((cur.value > NUM_POS_MAX) ? NUM_POS_MAX : cur.value);

endmodule
